// ===== design/humidity_temp_frame_decoder_defines.svh =====
// Assertion macros for the humidity/temperature frame decoder.
// Included by the top level; depends on nothing else.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 step for the frame decoder.
// Used by htfd_frame_parse and humidity_temp_frame_decoder.
package htfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [2:0]  FRAME_LAST  = 3'd6;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    // Raw fields of one completed frame.
    typedef struct packed {
        logic [7:0]  status;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic        crc_ok;
    } t_frame_res;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/htfd_frame_parse.sv =====
// Frame tracker: byte position, running CRC and payload collection.
// Depends on htfd_pkg for the CRC step and the result struct.
module htfd_frame_parse import htfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    output logic       o_done,
    output t_frame_res o_res
);

    logic [2:0]  r_pos,    n_pos;
    logic [7:0]  r_crc,    n_crc;
    logic [39:0] r_shift,  n_shift;
    logic [7:0]  r_status, n_status;
    logic        done;

    // Next frame state for the byte being transferred.
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_shift  = r_shift;
        n_status = r_status;
        done     = 1'b0;
        if (i_accept) begin
            if (i_first) begin
                n_status = i_byte;
                n_crc    = crc8_update(CRC_INIT, i_byte);
                n_shift  = '0;
                n_pos    = 3'd1;
            end else if (r_pos == 3'd0 || r_pos > FRAME_LAST) begin
                n_pos = 3'd0;
            end else if (r_pos < FRAME_LAST) begin
                n_crc   = crc8_update(r_crc, i_byte);
                n_shift = {r_shift[31:0], i_byte};
                n_pos   = r_pos + 3'd1;
            end else begin
                done  = 1'b1;
                n_pos = 3'd0;
                n_crc = CRC_INIT;
            end
        end
    end

    // Control state is reset; payload is always loaded by a start byte first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_crc <= CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
        r_shift  <= n_shift;
        r_status <= n_status;
    end

    // Raw fields of the frame that ends with this check byte.
    always_comb begin
        o_done         = done;
        o_res.status   = r_status;
        o_res.hum_raw  = r_shift[39:20];
        o_res.temp_raw = r_shift[19:0];
        o_res.crc_ok   = (i_byte == r_crc);
    end

endmodule

// ===== design/humidity_temp_frame_decoder.sv =====
// Channel | Dir | tdata (low bit up)                                  | tuser
// s       | in  | data_byte[7:0]                                      | first_byte
// m       | out | status, hum raw, temp raw, hum centi, temp centi, 0s | crc_ok
//
// One byte is taken per cycle while o_s_tready is high; a result goes from
// stage one (raw fields) to stage two (scaled output, one multiply each).
// Reset clears the frame position and both stage valids and sets the running CRC to its initial value.
// A stalled output backs up into stage one; input stalls only when both are full.
// Top level of the sensor frame decoder; depends on htfd_pkg, htfd_frame_parse
// and humidity_temp_frame_decoder_defines.svh.
`include "humidity_temp_frame_decoder_defines.svh"
module humidity_temp_frame_decoder import htfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] first_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [7:0] status_byte, [27:8] humidity_raw,
                                     // [47:28] temperature_raw, [61:48] humidity_centi,
                                     // [76:62] temperature_centi, [79:77] zero
    output logic [0:0]  o_m_tuser    // [0] crc_ok
);

    logic        in_xfer;
    logic        s1_adv;
    logic        frame_done;
    t_frame_res  frame_res;

    logic        r_s1_valid, n_s1_valid;
    t_frame_res  r_s1;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_status;
    logic [19:0] r_hum_raw;
    logic [19:0] r_temp_raw;
    logic [13:0] r_hum_centi;
    logic [14:0] r_temp_centi;
    logic        r_crc_ok;

    logic [33:0] hum_prod;
    logic [34:0] temp_prod;
    logic [14:0] temp_centi;

    // Handshake: stage one moves on when the output register is free or drains.
    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    htfd_frame_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_byte   (i_s_tdata),
        .i_first  (i_s_tuser[0]),
        .o_done   (frame_done),
        .o_res    (frame_res)
    );

    // Stage valids.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer && frame_done) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = s1_adv ? r_s1_valid : r_out_valid;
    end

    // Scaling of the raw codes held in stage one.
    always_comb begin
        hum_prod   = {14'd0, r_s1.hum_raw} * {20'd0, HUM_SCALE};
        temp_prod  = {15'd0, r_s1.temp_raw} * {20'd0, TEMP_SCALE};
        temp_centi = temp_prod[34:20] - TEMP_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        if (in_xfer && frame_done) begin
            r_s1 <= frame_res;
        end
        if (s1_adv && r_s1_valid) begin
            r_status     <= r_s1.status;
            r_hum_raw    <= r_s1.hum_raw;
            r_temp_raw   <= r_s1.temp_raw;
            r_hum_centi  <= hum_prod[33:20];
            r_temp_centi <= temp_centi;
            r_crc_ok     <= r_s1.crc_ok;
        end
    end

    // Output packing.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_temp_centi, r_hum_centi, r_temp_raw, r_hum_raw, r_status};
    assign o_m_tuser  = r_crc_ok;

    // Checks on the pipeline and the scaled ranges.
    `HTFD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid)
    `HTFD_ASSERT_NOW(a_hum_range, i_clk, i_rst_n, r_out_valid, r_hum_centi <= 14'd9999)
    `HTFD_ASSERT_NOW(a_temp_range, i_clk, i_rst_n, r_out_valid, $signed(r_temp_centi) >= -15'sd5000 && $signed(r_temp_centi) <= 15'sd14999)

endmodule

// ===== test/tb_humidity_temp_frame_decoder.sv =====
`timescale 1ns / 100ps
// Testbench for the humidity/temperature sensor frame decoder.
// Drives byte streams into humidity_temp_frame_decoder and scores every result;
// depends on the RTL top level only.

// Expected contents of one decoded frame.
typedef struct packed {
    logic [7:0]  status;
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
    logic [13:0] hum_centi;
    logic [14:0] temp_centi;
    logic        crc_ok;
} t_reading;

// Tracks the frame decoder state and the queue of readings still owed by the block.
class frame_board;
    localparam bit [7:0] SEED = 8'hFF;
    localparam bit [7:0] GEN  = 8'h31;
    localparam int       PRINT_CAP = 100;

    bit [2:0]    pos;
    bit [7:0]    crc;
    bit [39:0]   payload;
    bit [7:0]    status;
    t_reading    due_q[$];
    int unsigned fail_count;
    int unsigned used_count;

    function new();
        pos        = 3'd0;
        crc        = SEED;
        payload    = 40'd0;
        status     = 8'd0;
        fail_count = 0;
        used_count = 0;
    endfunction

    // One byte of CRC-8, most significant bit first.
    static function bit [7:0] crc_byte(input bit [7:0] acc, input bit [7:0] b);
        bit [7:0] r;
        bit       top;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            top = r[7] ^ b[k];
            r = {r[6:0], 1'b0};
            if (top) begin
                r = r ^ GEN;
            end
        end
        return r;
    endfunction

    // Advance the decoder state by one accepted input transfer.
    function void note_input(input bit [7:0] b, input bit first);
        t_reading  r;
        bit [34:0] hum_prod;
        bit [34:0] temp_prod;
        if (first) begin
            // A status byte always restarts the frame.
            status  = b;
            crc     = crc_byte(SEED, b);
            payload = 40'd0;
            pos     = 3'd1;
            used_count++;
        end else if (pos == 3'd0) begin
            // Stray byte while idle: no effect.
        end else if (pos < 3'd6) begin
            crc     = crc_byte(crc, b);
            payload = {payload[31:0], b};
            pos     = pos + 3'd1;
            used_count++;
        end else begin
            // Check byte: the frame completes and one reading is owed.
            r.status     = status;
            r.hum_raw    = payload[39:20];
            r.temp_raw   = payload[19:0];
            hum_prod     = {15'd0, r.hum_raw} * 35'd10000;
            temp_prod    = {15'd0, r.temp_raw} * 35'd20000;
            r.hum_centi  = hum_prod[33:20];
            r.temp_centi = temp_prod[34:20] - 15'd5000;
            r.crc_ok     = (b == crc);
            due_q.push_back(r);
            pos = 3'd0;
            crc = SEED;
            used_count++;
        end
    endfunction

    task report_mismatch(input string what, input logic [79:0] got, input logic [79:0] wanted);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, wanted);
        end
    endtask

    // Compare one accepted output transfer with the oldest owed reading.
    task check_result(input logic [79:0] data, input logic [0:0] user);
        t_reading want;
        if (due_q.size() == 0) begin
            report_mismatch("result with nothing pending", data, 80'd0);
            return;
        end
        want = due_q.pop_front();
        if (data[7:0] !== want.status) begin
            report_mismatch("status_byte", 80'(data[7:0]), 80'(want.status));
        end
        if (data[27:8] !== want.hum_raw) begin
            report_mismatch("humidity_raw", 80'(data[27:8]), 80'(want.hum_raw));
        end
        if (data[47:28] !== want.temp_raw) begin
            report_mismatch("temperature_raw", 80'(data[47:28]), 80'(want.temp_raw));
        end
        if (data[61:48] !== want.hum_centi) begin
            report_mismatch("humidity_centi", 80'(data[61:48]), 80'(want.hum_centi));
        end
        if (data[76:62] !== want.temp_centi) begin
            report_mismatch("temperature_centi", 80'(data[76:62]), 80'(want.temp_centi));
        end
        if (data[79:77] !== 3'd0) begin
            report_mismatch("tdata padding", 80'(data[79:77]), 80'd0);
        end
        if (user[0] !== want.crc_ok) begin
            report_mismatch("crc_ok", 80'(user[0]), 80'(want.crc_ok));
        end
    endtask
endclass

module tb_humidity_temp_frame_decoder;

    localparam int RANDOM_ITEMS = 1925;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_CUT,
        FRAME_NOISE
    } t_frame_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [0:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    int          send_idle_pct = 12;
    int          recv_stall_pct = 88;
    int          quiet_cycles = 0;
    frame_board  board = new();

    humidity_temp_frame_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Free-running clock, 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure, redrawn at every falling edge.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Score every accepted output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tuser);
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one byte, with random idle cycles ahead of it; called at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= first;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        board.note_input(b, first);
        @(negedge i_clk);
    endtask

    // Send the first n_bytes of a frame; the check byte is the CRC xor crc_flip.
    task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                              input logic [7:0] crc_flip, input int n_bytes);
        logic [7:0] crc;
        logic [7:0] b;
        crc = board.crc_byte(8'hFF, status);
        send_byte(status, 1'b1);
        for (int k = 1; k < n_bytes && k <= 5; k++) begin
            b   = payload[47 - 8 * k -: 8];
            crc = board.crc_byte(crc, b);
            send_byte(b, 1'b0);
        end
        if (n_bytes >= 7) begin
            send_byte(crc ^ crc_flip, 1'b0);
        end
    endtask

    // Random payload, now and then pinned to an extreme code.
    function automatic logic [39:0] pick_payload();
        logic [39:0] p;
        p = {8'($urandom_range(255)), $urandom};
        case ($urandom_range(9))
            0: p[39:20] = 20'h00000;
            1: p[39:20] = 20'hFFFFF;
            2: p[19:0]  = 20'h00000;
            3: p[19:0]  = 20'hFFFFF;
            default: ;
        endcase
        return p;
    endfunction

    // Main sequence: reset, directed frames, random frames, drain.
    initial begin
        int          base;
        int          progress;
        int          drain;
        t_frame_kind kind;
        i_rst_n        <= 1'b0;
        i_s_tvalid     <= 1'b0;
        i_s_tdata      <= 8'd0;
        i_s_tuser      <= 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a stray byte while idle, zero codes with a good CRC,
        // full-scale codes with a bad CRC, and a restart inside a frame.
        send_byte(8'hFF, 1'b0);
        send_frame(8'h00, 40'h00000_00000, 8'h00, 7);
        send_frame(8'hFF, 40'hFFFFF_FFFFF, 8'h01, 7);
        send_frame(8'h1C, 40'hA5C3F_0F00F, 8'h00, 3);
        send_frame(8'h18, 40'h12345_ABCDE, 8'h00, 7);

        // Random part in three idling phases, mostly well-formed frames.
        base = board.used_count;
        progress = 0;
        while (progress < RANDOM_ITEMS) begin
            if (progress < RANDOM_ITEMS / 3) begin
                send_idle_pct  = 12;
                recv_stall_pct = 88;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 88;
                recv_stall_pct = 12;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case ($urandom_range(19))
                0, 1:    kind = FRAME_BAD_CRC;
                2, 3:    kind = FRAME_CUT;
                4:       kind = FRAME_NOISE;
                default: kind = FRAME_GOOD;
            endcase
            case (kind)
                FRAME_GOOD: begin
                    send_frame(8'($urandom_range(255)), pick_payload(), 8'h00, 7);
                end
                FRAME_BAD_CRC: begin
                    send_frame(8'($urandom_range(255)), pick_payload(),
                               8'($urandom_range(255, 1)), 7);
                end
                FRAME_CUT: begin
                    // The next status byte restarts this frame, at the check byte too.
                    send_frame(8'($urandom_range(255)), pick_payload(), 8'h00,
                               int'($urandom_range(6, 1)));
                end
                FRAME_NOISE: begin
                    repeat ($urandom_range(3, 1)) begin
                        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                    end
                end
                default: ;
            endcase
            progress = board.used_count - base;
        end
        i_s_tvalid <= 1'b0;

        // Wait for every owed reading, then watch the output for anything extra.
        drain = 0;
        while (board.due_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (board.due_q.size() != 0) begin
            board.report_mismatch("readings never delivered", 80'(board.due_q.size()), 80'd0);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
